// File: src/safm_pkg.sv
// Shared types, constants and encoders for the stick-arming flight-mode unit.
// No dependencies; used by the top level and the port checker.
package safm_pkg;

  localparam int unsigned TICK_WIDTH = 32;  // tick arithmetic wraps at 2^TICK_WIDTH
  localparam int unsigned MISS_WIDTH = 8;   // loss counter width, wraps

  localparam int unsigned MISS_CMP_W = (MISS_WIDTH > 8) ? MISS_WIDTH : 8;

  localparam int unsigned IN_DATA_W  = 56;  // 49 payload bits padded to bytes
  localparam int unsigned OUT_DATA_W = 16;  // 14 payload bits padded to bytes
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_HIGH_THR   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LOW_THR    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_HOLD_TICKS = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_WIN_TICKS  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_LOSS_LIM   = 3'd4;

  localparam logic [15:0] HIGH_THR_RST   = 16'd900;
  localparam logic [15:0] LOW_THR_RST    = 16'd100;
  localparam logic [15:0] HOLD_TICKS_RST = 16'd1000;
  localparam logic [15:0] WIN_TICKS_RST  = 16'd1000;
  localparam logic [7:0]  LOSS_LIM_RST   = 8'd10;

  // external codes on the result word
  localparam logic [1:0] MODE_CODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_CODE_NORMAL = 2'd1;
  localparam logic [1:0] MODE_CODE_HOLD   = 2'd2;
  localparam logic [1:0] MODE_CODE_FAIL   = 2'd3;

  localparam logic [2:0] ARM_CODE_FREE   = 3'd0;
  localparam logic [2:0] ARM_CODE_HIGH   = 3'd1;
  localparam logic [2:0] ARM_CODE_LEFT   = 3'd2;
  localparam logic [2:0] ARM_CODE_LOW    = 3'd3;
  localparam logic [2:0] ARM_CODE_UNLOCK = 3'd4;

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_NORMAL = 4'b0010,
    MODE_HOLD   = 4'b0100,
    MODE_FAIL   = 4'b1000
  } mode_t;

  typedef enum logic [4:0] {
    ARM_FREE   = 5'b00001,
    ARM_HIGH   = 5'b00010,
    ARM_LEFT   = 5'b00100,
    ARM_LOW    = 5'b01000,
    ARM_UNLOCK = 5'b10000
  } arm_t;

  function automatic logic [1:0] mode_code(input mode_t m);
    logic [1:0] c;
    unique case (m)
      MODE_IDLE:   c = MODE_CODE_IDLE;
      MODE_NORMAL: c = MODE_CODE_NORMAL;
      MODE_HOLD:   c = MODE_CODE_HOLD;
      MODE_FAIL:   c = MODE_CODE_FAIL;
      default:     c = MODE_CODE_IDLE;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] arm_code(input arm_t a);
    logic [2:0] c;
    unique case (a)
      ARM_FREE:   c = ARM_CODE_FREE;
      ARM_HIGH:   c = ARM_CODE_HIGH;
      ARM_LEFT:   c = ARM_CODE_LEFT;
      ARM_LOW:    c = ARM_CODE_LOW;
      ARM_UNLOCK: c = ARM_CODE_UNLOCK;
      default:    c = ARM_CODE_FREE;
    endcase
    return c;
  endfunction

endpackage

// File: src/stick_arming_flight_mode_fsm_unit.sv
// Stick-arming flight-mode unit: link tracker, throttle arming sequence, mode FSM.
// Depends on safm_pkg.
//
//  port group | dir | word contents (lsb first)
//  -----------+-----+----------------------------------------------------------
//  in_*       | in  | tuser: packet_ok; tdata: throttle[15:0],
//             |     |   hold_toggle_req[16], now_ticks[48:17], zero pad
//  out_*      | out | tdata: mode[1:0], link_up[2], arm_phase[5:3],
//             |     |   miss_count[13:6], zero pad
//  cfg_*      | in  | write only: cfg_we, cfg_addr (register index), cfg_wdata
//
// Pipeline: two-stage pipe, an input register then the result register; an
// accepted word is held in the input register and moves into the result
// register when the result stage is free, as the second stage updates the
// state. One word per clock is sustained while out_tready stays high.
// Reset: rst_n synchronous, active low; clears valids, state and config.
// Stalls: out_tready low holds the result; the input register still takes a
// word while it is empty or the result stage is free or draining.

module stick_arming_flight_mode_fsm_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [safm_pkg::IN_DATA_W-1:0]    in_tdata,   // throttle, hold_toggle_req, now_ticks
  input  logic                              in_tuser,   // packet_ok
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [safm_pkg::OUT_DATA_W-1:0]   out_tdata,  // mode, link_up, arm_phase, miss_count
  input  logic                              cfg_we,
  input  logic [safm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [safm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int unsigned TW = safm_pkg::TICK_WIDTH;
  localparam int unsigned MW = safm_pkg::MISS_WIDTH;
  localparam int unsigned CW = safm_pkg::MISS_CMP_W;

  // ---------------- configuration registers ----------------
  logic [15:0] high_thr_r, low_thr_r, hold_ticks_r, win_ticks_r;
  logic [7:0]  loss_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_thr_r   <= safm_pkg::HIGH_THR_RST;
      low_thr_r    <= safm_pkg::LOW_THR_RST;
      hold_ticks_r <= safm_pkg::HOLD_TICKS_RST;
      win_ticks_r  <= safm_pkg::WIN_TICKS_RST;
      loss_lim_r   <= safm_pkg::LOSS_LIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        safm_pkg::REG_HIGH_THR:   high_thr_r   <= cfg_wdata;
        safm_pkg::REG_LOW_THR:    low_thr_r    <= cfg_wdata;
        safm_pkg::REG_HOLD_TICKS: hold_ticks_r <= cfg_wdata;
        safm_pkg::REG_WIN_TICKS:  win_ticks_r  <= cfg_wdata;
        safm_pkg::REG_LOSS_LIM:   loss_lim_r   <= cfg_wdata[7:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------- pipeline handshake ----------------
  logic s1_valid_r;
  logic out_free;   // result stage can load this cycle
  logic s1_adv;     // stage 1 word moves into the result stage

  assign out_free  = !out_tvalid || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  // ---------------- stage 1: input register ----------------
  logic        ok_r;
  logic [15:0] thr_r;
  logic        req_r;
  logic [TW-1:0] now_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ok_r  <= in_tuser;
      thr_r <= in_tdata[15:0];
      req_r <= in_tdata[16];
      now_r <= TW'(in_tdata[48:17]);
    end
  end

  // ---------------- state ----------------
  safm_pkg::mode_t mode_r, mode_nxt;
  safm_pkg::arm_t  arm_r, arm_nxt;
  logic [TW-1:0]   phase_start_r, phase_start_nxt;
  logic [MW-1:0]   miss_r, miss_nxt;
  logic            link_r, link_nxt;
  logic [15:0]     held_thr_r, held_thr_nxt;
  logic            toggle_r, toggle_nxt;

  // ---------------- stage 2: update logic ----------------
  logic [MW-1:0] miss_inc;
  logic [TW-1:0] elapsed;
  logic          arm_en;

  assign miss_inc = miss_r + MW'(1);
  assign elapsed  = now_r - phase_start_r;   // wraps mod 2^TICK_WIDTH

  always_comb begin
    // link tracker and latch from good packets
    link_nxt     = link_r;
    miss_nxt     = miss_r;
    held_thr_nxt = held_thr_r;
    toggle_nxt   = toggle_r;
    if (ok_r) begin
      link_nxt     = 1'b1;
      miss_nxt     = '0;
      held_thr_nxt = thr_r;
      toggle_nxt   = req_r;
    end else begin
      miss_nxt = miss_inc;
      if (CW'(miss_inc) >= CW'(loss_lim_r)) begin
        link_nxt = 1'b0;
        miss_nxt = '0;
      end
    end

    // arming sequence, only stepped while idle
    arm_en          = (mode_r == safm_pkg::MODE_IDLE);
    arm_nxt         = arm_r;
    phase_start_nxt = phase_start_r;
    if (arm_en) begin
      unique case (arm_r)
        safm_pkg::ARM_FREE: begin
          if (held_thr_nxt >= high_thr_r) begin
            arm_nxt         = safm_pkg::ARM_HIGH;
            phase_start_nxt = now_r;
          end
        end
        safm_pkg::ARM_HIGH: begin
          if (held_thr_nxt <= high_thr_r)
            arm_nxt = (elapsed >= TW'(hold_ticks_r)) ? safm_pkg::ARM_LEFT
                                                     : safm_pkg::ARM_FREE;
        end
        safm_pkg::ARM_LEFT: begin
          if (held_thr_nxt <= low_thr_r) begin
            arm_nxt         = safm_pkg::ARM_LOW;
            phase_start_nxt = now_r;
          end
        end
        safm_pkg::ARM_LOW: begin
          // inside the window: stick still down unlocks, else start over
          if (elapsed <= TW'(win_ticks_r))
            arm_nxt = (held_thr_nxt > low_thr_r) ? safm_pkg::ARM_FREE
                                                 : safm_pkg::ARM_UNLOCK;
          else
            arm_nxt = safm_pkg::ARM_FREE;
        end
        default: ;  // unlocked never persists; hold
      endcase
    end

    // mode machine
    mode_nxt = mode_r;
    unique case (mode_r)
      safm_pkg::MODE_IDLE: begin
        if (arm_nxt == safm_pkg::ARM_UNLOCK) begin
          mode_nxt = safm_pkg::MODE_NORMAL;
          arm_nxt  = safm_pkg::ARM_FREE;
        end
      end
      safm_pkg::MODE_NORMAL, safm_pkg::MODE_HOLD: begin
        if (toggle_nxt) begin
          mode_nxt   = (mode_r == safm_pkg::MODE_NORMAL) ? safm_pkg::MODE_HOLD
                                                         : safm_pkg::MODE_NORMAL;
          toggle_nxt = 1'b0;
        end
        if (!link_nxt) mode_nxt = safm_pkg::MODE_FAIL;  // link loss beats a toggle
      end
      default: mode_nxt = safm_pkg::MODE_IDLE;          // fail lasts one word
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= safm_pkg::MODE_IDLE;
      arm_r         <= safm_pkg::ARM_FREE;
      phase_start_r <= '0;
      miss_r        <= '0;
      link_r        <= 1'b0;
      held_thr_r    <= '0;
      toggle_r      <= 1'b0;
    end else if (s1_adv) begin
      mode_r        <= mode_nxt;
      arm_r         <= arm_nxt;
      phase_start_r <= phase_start_nxt;
      miss_r        <= miss_nxt;
      link_r        <= link_nxt;
      held_thr_r    <= held_thr_nxt;
      toggle_r      <= toggle_nxt;
    end
  end

  // ---------------- result register ----------------
  logic out_valid_r;
  logic [safm_pkg::OUT_DATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= {2'b00, 8'(miss_nxt), safm_pkg::arm_code(arm_nxt), link_nxt,
                     safm_pkg::mode_code(mode_nxt)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: src/safm_checker.sv
// Port-level checker for the stick-arming flight-mode unit, bound to the top.
// Depends on safm_pkg.
module safm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [safm_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic [1:0] mode_f;
  logic       link_f;
  logic [2:0] arm_f;

  assign mode_f = out_tdata[1:0];
  assign link_f = out_tdata[2];
  assign arm_f  = out_tdata[5:3];

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed under stall");

  // unlock folds straight into normal mode, so the phase never shows unlocked
  a_arm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> arm_f != safm_pkg::ARM_CODE_UNLOCK && arm_f <= safm_pkg::ARM_CODE_LOW)
    else $error("arm phase out of reachable range");

  // fail is only entered on a lost link
  a_fail_link: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && mode_f == safm_pkg::MODE_CODE_FAIL |-> !link_f)
    else $error("fail mode with link up");

  // arming only runs while idle
  a_arm_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && mode_f != safm_pkg::MODE_CODE_IDLE |-> arm_f == safm_pkg::ARM_CODE_FREE)
    else $error("arm phase moved outside idle");

endmodule

bind stick_arming_flight_mode_fsm_unit safm_checker u_safm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
